FILE: hw/rtl/ppm_fd_pkg.sv
// ============================================================================
// ppm_fd_pkg
// Shared types and constants for the PPM frame decoder.
// ============================================================================
`default_nettype none

package ppm_fd_pkg;

  localparam int TIME_W  = 16;
  localparam int VALUE_W = 12;
  localparam int CHAN_W  = 5;
  localparam int RDCH_W  = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd4095;

  localparam logic [TIME_W-1:0] PULSE_LIMIT_RST = 16'd500;
  localparam logic [TIME_W-1:0] SYNC_LIMIT_RST  = 16'd3000;
  localparam logic [TIME_W-1:0] MIN_VALUE_RST   = 16'd810;
  localparam logic [TIME_W-1:0] MAX_VALUE_RST   = 16'd2210;

  typedef enum logic [1:0] {
    EV_MARK   = 2'd0,
    EV_SYNC   = 2'd1,
    EV_ACCEPT = 2'd2,
    EV_REJECT = 2'd3
  } ppm_fd_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_LIMIT = 2'd0,
    CFG_SYNC_LIMIT  = 2'd1,
    CFG_MIN_VALUE   = 2'd2,
    CFG_MAX_VALUE   = 2'd3
  } ppm_fd_cfg_t;

  // channel table write request
  typedef struct packed {
    logic               en;
    logic [CHAN_W-1:0]  index;
    logic [VALUE_W-1:0] value;
  } ppm_fd_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ppm_fd_chan_table.sv
// ============================================================================
// ppm_fd_chan_table
// Channel value table: one write port, one read port with write-through.
// ============================================================================
`default_nettype none

module ppm_fd_chan_table
  import ppm_fd_pkg::*;
#(
  parameter int CHANNEL_COUNT = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ppm_fd_wr_t         wr,
  input  wire logic [RDCH_W-1:0]  rd_channel,
  output logic      [VALUE_W-1:0] rd_value
);

  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [CHAN_W-1:0] CH_CNT = CHAN_W'(CHANNEL_COUNT);

  logic [VALUE_W-1:0] values_r [CHANNEL_COUNT];
  logic [CHAN_W-1:0]  rd_ext;
  logic               rd_ok;
  logic               rd_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        values_r[i] <= '0;
      end
    end else if (wr.en) begin
      values_r[wr.index[AW-1:0]] <= wr.value;
    end
  end

  assign rd_ext = {{(CHAN_W-RDCH_W){1'b0}}, rd_channel};
  assign rd_ok  = rd_ext < CH_CNT;
  assign rd_hit = wr.en && (wr.index == rd_ext);

  always_comb begin
    if (!rd_ok) begin
      rd_value = '0;
    end else if (rd_hit) begin
      rd_value = wr.value;
    end else begin
      rd_value = values_r[rd_channel[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ppm_frame_decoder_core.sv
// ============================================================================
// ppm_frame_decoder_core
// PPM frame decoder: edge timestamps in, classified intervals and channel
// values out.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_stall) carries one edge timestamp plus the
//   channel to read back. Output channel (out_valid/out_stall) returns one
//   item per edge: event kind, channel index, channel sum, readback value.
//   cfg_valid/cfg_ready writes the four limit registers; cfg_ready is always
//   high. Write config only while no item is in flight.
//   Path: an item passes the input register, then the result register,
//   before out_valid rises. Rate: one item per cycle while out_stall is low,
//   set by the single subtract/add/compare pass between the two registers.
//   Reset: limits return to defaults, the channel table, index, mark length
//   and previous timestamp clear to zero, both channels go empty.
//   Stall: a stalled result holds; the input register keeps its item and
//   in_stall rises once it is full, so nothing is dropped.
// ============================================================================
`default_nettype none

module ppm_frame_decoder_core
  import ppm_fd_pkg::*;
#(
  parameter int CHANNEL_COUNT = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [TIME_W-1:0]    in_edge_time,
  input  wire logic [RDCH_W-1:0]    in_read_channel,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                out_event_kind,
  output logic [CHAN_W-1:0]         out_written_channel,
  output logic [VALUE_W-1:0]        out_written_value,
  output logic [VALUE_W-1:0]        out_read_value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TIME_W-1:0]    cfg_data
);

  localparam logic [CHAN_W-1:0] CH_CNT = CHAN_W'(CHANNEL_COUNT);

  logic [TIME_W-1:0]  pulse_limit_r, sync_limit_r, min_value_r, max_value_r;
  logic [TIME_W-1:0]  prev_time_r, mark_r, mark_nxt;
  logic [CHAN_W-1:0]  chan_idx_r, chan_idx_nxt;

  logic               s1_valid_r;
  logic [TIME_W-1:0]  s1_time_r;
  logic [RDCH_W-1:0]  s1_rdch_r;

  logic               out_valid_r;
  ppm_fd_event_t      out_kind_r, kind_nxt;
  logic [CHAN_W-1:0]  out_wch_r, wch_nxt;
  logic [VALUE_W-1:0] out_wval_r, wval_nxt;
  logic [VALUE_W-1:0] out_rval_r;

  logic               adv, fire, wr_ok;
  logic [TIME_W-1:0]  interval;
  logic [TIME_W:0]    sum;
  logic [VALUE_W-1:0] sat;
  logic               in_win;
  ppm_fd_wr_t         tbl_wr;
  logic [VALUE_W-1:0] tbl_rd_value;

  // handshake
  assign adv       = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && adv;
  assign in_stall  = s1_valid_r && !adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_limit_r <= PULSE_LIMIT_RST;
      sync_limit_r  <= SYNC_LIMIT_RST;
      min_value_r   <= MIN_VALUE_RST;
      max_value_r   <= MAX_VALUE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ppm_fd_cfg_t'(cfg_index))
        CFG_PULSE_LIMIT: pulse_limit_r <= cfg_data;
        CFG_SYNC_LIMIT:  sync_limit_r  <= cfg_data;
        CFG_MIN_VALUE:   min_value_r   <= cfg_data;
        CFG_MAX_VALUE:   max_value_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_time_r <= in_edge_time;
      s1_rdch_r <= in_read_channel;
    end
  end

  // classification
  assign interval = s1_time_r - prev_time_r;
  assign sum      = {1'b0, interval} + {1'b0, mark_r};
  assign sat      = (sum > (TIME_W+1)'(VALUE_MAX)) ? VALUE_MAX : sum[VALUE_W-1:0];
  assign in_win   = (sum > {1'b0, min_value_r}) && (sum < {1'b0, max_value_r});

  always_comb begin
    mark_nxt     = mark_r;
    chan_idx_nxt = chan_idx_r;
    kind_nxt     = EV_MARK;
    wch_nxt      = chan_idx_r;
    wval_nxt     = '0;
    wr_ok        = 1'b0;
    if (interval < pulse_limit_r) begin
      mark_nxt = interval;
    end else if (interval > sync_limit_r) begin
      kind_nxt     = EV_SYNC;
      wch_nxt      = '0;
      chan_idx_nxt = '0;
    end else begin
      wval_nxt = sat;
      if (in_win) begin
        kind_nxt = EV_ACCEPT;
        if (chan_idx_r < CH_CNT) begin
          wr_ok        = 1'b1;
          chan_idx_nxt = chan_idx_r + CHAN_W'(1);
        end
      end else begin
        kind_nxt = EV_REJECT;
      end
    end
  end

  assign tbl_wr.en    = fire && wr_ok;
  assign tbl_wr.index = chan_idx_r;
  assign tbl_wr.value = sat;

  ppm_fd_chan_table #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (tbl_wr),
    .rd_channel (s1_rdch_r),
    .rd_value   (tbl_rd_value)
  );

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r <= '0;
      mark_r      <= '0;
      chan_idx_r  <= '0;
    end else if (fire) begin
      prev_time_r <= s1_time_r;
      mark_r      <= mark_nxt;
      chan_idx_r  <= chan_idx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_kind_r <= kind_nxt;
      out_wch_r  <= wch_nxt;
      out_wval_r <= wval_nxt;
      out_rval_r <= tbl_rd_value;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = out_kind_r;
  assign out_written_channel = out_wch_r;
  assign out_written_value   = out_wval_r;
  assign out_read_value      = out_rval_r;

endmodule

`default_nettype wire

FILE: hw/rtl/ppm_fd_checker.sv
// ============================================================================
// ppm_fd_checker
// Port-level checks for the PPM frame decoder, bound to the top level.
// ============================================================================
`default_nettype none

module ppm_fd_checker
  import ppm_fd_pkg::*;
#(
  parameter int CHANNEL_COUNT = 8
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         out_event_kind,
  input wire logic [CHAN_W-1:0]  out_written_channel,
  input wire logic [VALUE_W-1:0] out_written_value,
  input wire logic [VALUE_W-1:0] out_read_value
);

  localparam logic [CHAN_W-1:0] CH_CNT = CHAN_W'(CHANNEL_COUNT);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_written_channel) && $stable(out_written_value)
      && $stable(out_read_value))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_sync_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_SYNC)
      |-> (out_written_channel == '0) && (out_written_value == '0))
    else $error("sync result with nonzero channel or value");

  a_mark_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_kind == EV_MARK) |-> (out_written_value == '0))
    else $error("mark result with nonzero value");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_written_channel <= CH_CNT))
    else $error("channel index past channel count");

endmodule

bind ppm_frame_decoder_core ppm_fd_checker #(
  .CHANNEL_COUNT(CHANNEL_COUNT)
) u_ppm_fd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_event_kind      (out_event_kind),
  .out_written_channel (out_written_channel),
  .out_written_value   (out_written_value),
  .out_read_value      (out_read_value)
);

`default_nettype wire

FILE: sim/tb_top.sv
// ============================================================================
// tb_top - testbench for ppm_frame_decoder_core
// Edge timestamps are fed as PPM-like traffic: well-formed frames of sync gap,
// mark and space, plus noise intervals. A per-edge decoder model predicts
// every result. Random gaps and stalls are applied on both channels, and the
// limit registers are reloaded between traffic phases.
// ============================================================================
module tb_top
  import ppm_fd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_CH       = 8;
  localparam int IDLE_PCT     = 12;
  localparam int DRAIN_CYCLES = 6;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_PRINTS   = 40;

  typedef struct packed {
    logic [TIME_W-1:0] edge_time;
    logic [RDCH_W-1:0] read_channel;
  } edge_item_t;

  typedef struct {
    ppm_fd_event_t      kind;
    logic [CHAN_W-1:0]  chan;
    logic [VALUE_W-1:0] wval;
    logic [VALUE_W-1:0] rval;
  } ppm_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_edge_time = '0;
  logic [RDCH_W-1:0]    in_read_channel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_event_kind;
  logic [CHAN_W-1:0]    out_written_channel;
  logic [VALUE_W-1:0]   out_written_value;
  logic [VALUE_W-1:0]   out_read_value;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  // decoder model state and limit registers
  logic [TIME_W-1:0]  last_edge;
  logic [TIME_W-1:0]  mark_len;
  logic [CHAN_W-1:0]  chan_idx;
  logic [VALUE_W-1:0] chan_tbl [NUM_CH];
  logic [TIME_W-1:0]  pulse_lim, sync_lim, min_val, max_val;

  edge_item_t  edge_queue [$];
  ppm_result_t expected_events [$];
  edge_item_t  next_edge;
  ppm_result_t want;

  logic [TIME_W-1:0] now_us = '0;
  int items_pushed = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int settings     = 1;
  int errors       = 0;
  int cycles       = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  bit no_gaps      = 1'b0;

  ppm_frame_decoder_core #(.CHANNEL_COUNT(NUM_CH)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_edge_time        (in_edge_time),
    .in_read_channel     (in_read_channel),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_kind      (out_event_kind),
    .out_written_channel (out_written_channel),
    .out_written_value   (out_written_value),
    .out_read_value      (out_read_value),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void decode_edge(input logic [TIME_W-1:0] t,
                                      input logic [RDCH_W-1:0] rd);
    logic [TIME_W-1:0]  gap;
    logic [TIME_W:0]    sum;
    logic [VALUE_W-1:0] sat;
    ppm_result_t        r;
    gap = t - last_edge;
    last_edge = t;
    r.wval = '0;
    if (gap < pulse_lim) begin
      mark_len = gap;
      r.kind = EV_MARK;
      r.chan = chan_idx;
    end else if (gap > sync_lim) begin
      chan_idx = '0;
      r.kind = EV_SYNC;
      r.chan = '0;
    end else begin
      sum = {1'b0, gap} + {1'b0, mark_len};
      sat = (sum > VALUE_MAX) ? VALUE_MAX : sum[VALUE_W-1:0];
      r.chan = chan_idx;
      r.wval = sat;
      if (sum > min_val && sum < max_val) begin
        r.kind = EV_ACCEPT;
        if (chan_idx < NUM_CH) begin
          chan_tbl[chan_idx] = sat;
          chan_idx = chan_idx + 1'b1;
        end
      end else begin
        r.kind = EV_REJECT;
      end
    end
    r.rval = (rd < NUM_CH) ? chan_tbl[rd] : '0;
    kind_count[r.kind]++;
    expected_events.push_back(r);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_edge(in_edge_time, in_read_channel);
        items_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (edge_queue.size() > 0 && (no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
          next_edge = edge_queue.pop_front();
          in_valid        <= 1'b1;
          in_edge_time    <= next_edge.edge_time;
          in_read_channel <= next_edge.read_channel;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          flag_error("result with no edge pending");
        end else begin
          want = expected_events.pop_front();
          if (out_event_kind !== want.kind)
            flag_error($sformatf("event_kind got %0d want %s", out_event_kind,
                                 want.kind.name()));
          if (out_written_channel !== want.chan)
            flag_error($sformatf("written_channel got %0d want %0d",
                                 out_written_channel, want.chan));
          if (out_written_value !== want.wval)
            flag_error($sformatf("written_value got %0d want %0d",
                                 out_written_value, want.wval));
          if (out_read_value !== want.rval)
            flag_error($sformatf("read_value got %0d want %0d",
                                 out_read_value, want.rval));
        end
      end
      out_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // register writes seen by the model
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (ppm_fd_cfg_t'(cfg_index))
        CFG_PULSE_LIMIT: pulse_lim = cfg_data;
        CFG_SYNC_LIMIT:  sync_lim  = cfg_data;
        CFG_MIN_VALUE:   min_val   = cfg_data;
        CFG_MAX_VALUE:   max_val   = cfg_data;
        default: ;
      endcase
      cfg_writes++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic push_at(input logic [TIME_W-1:0] t, input logic [RDCH_W-1:0] rd);
    edge_item_t e;
    now_us = t;
    e.edge_time = t;
    e.read_channel = rd;
    edge_queue.push_back(e);
    items_pushed++;
  endtask

  task automatic push_gap(input int unsigned iv, input logic [RDCH_W-1:0] rd);
    push_at(now_us + iv[TIME_W-1:0], rd);
  endtask

  task automatic apply_config(input logic [TIME_W-1:0] p, input logic [TIME_W-1:0] s,
                              input logic [TIME_W-1:0] mn, input logic [TIME_W-1:0] mx);
    logic [TIME_W-1:0] vals [4];
    int target;
    vals = '{p, s, mn, mx};
    for (int i = 0; i < 4; i++) begin
      target = cfg_writes + 1;
      cfg_valid <= 1'b1;
      cfg_index <= ppm_fd_cfg_t'(i);
      cfg_data  <= vals[i];
      wait (cfg_writes == target);
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic drain();
    wait (results_seen >= items_pushed);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic gen_traffic(input int n, input int frame_pct);
    int unsigned start, nch, mk, sp, target, pl, sl, mn, mx, top;
    start = items_pushed;
    pl = pulse_lim;
    sl = sync_lim;
    mn = min_val;
    mx = max_val;
    while (items_pushed - start < n) begin
      if ($urandom_range(99) < frame_pct) begin
        top = (65535 - sl > 4000) ? sl + 4000 : 65535;
        push_gap($urandom_range(top, sl + 1), 4'($urandom_range(15)));
        nch = $urandom_range(10, 3);
        repeat (nch) begin
          mk = $urandom_range(pl - 1, 1);
          if ($urandom_range(99) < 95) push_gap(mk, 4'($urandom_range(15)));
          if ($urandom_range(99) < 85) target = $urandom_range(mx - 1, mn + 1);
          else target = $urandom_range(mx + 600);
          sp = (target > mk) ? target - mk : 0;
          if (sp < pl) sp = pl;
          if (sp > sl) sp = sl;
          push_gap(sp, 4'($urandom_range(15)));
        end
      end else begin
        case ($urandom_range(2))
          0: push_gap($urandom_range(65535), 4'($urandom_range(15)));
          1: push_gap($urandom_range(4000), 4'($urandom_range(15)));
          default: push_gap($urandom_range(1) ? 65535 : $urandom_range(3),
                            4'($urandom_range(15)));
        endcase
      end
    end
  endtask

  initial begin
    last_edge = '0;
    mark_len  = '0;
    chan_idx  = '0;
    for (int i = 0; i < NUM_CH; i++) chan_tbl[i] = '0;
    pulse_lim = PULSE_LIMIT_RST;
    sync_lim  = SYNC_LIMIT_RST;
    min_val   = MIN_VALUE_RST;
    max_val   = MAX_VALUE_RST;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: first edge from zero, window edges, table fill past the end
    push_gap(100, 0);
    push_gap(3001, 15);
    push_gap(400, 1);
    push_gap(1000, 0);
    push_gap(10, 2);
    push_gap(800, 3);
    push_gap(801, 1);
    push_gap(499, 4);
    push_gap(1710, 2);
    push_gap(1711, 5);
    push_gap(500, 3);
    push_gap(3000, 6);
    for (int i = 0; i < 6; i++) push_gap(1000, 4'(7 + i));
    push_gap(0, 8);
    push_gap(65535, 9);
    push_at(16'hFFFF, 10);
    push_at(16'h0000, 11);
    push_gap(1200, 12);
    push_gap(1, 13);
    push_gap(900, 14);
    drain();

    gen_traffic(280, 80);
    drain();

    // 17-bit sums, saturation, window at the register extremes
    apply_config(16'd3000, 16'd65534, 16'd0, 16'd65535);
    push_gap(65535, 0);
    push_gap(2999, 1);
    push_gap(65534, 2);
    push_gap(2999, 3);
    push_gap(3000, 0);
    push_gap(2999, 4);
    push_gap(62536, 5);
    push_gap(2999, 6);
    push_gap(62535, 1);
    push_gap(3000, 2);
    push_gap(0, 7);
    push_gap(3000, 3);
    drain();

    apply_config(16'd0, 16'd0, 16'd65535, 16'd0);
    gen_traffic(40, 0);
    drain();

    // crossed limits: pulse test wins
    apply_config(16'd4000, 16'd1000, 16'd100, 16'd6000);
    gen_traffic(40, 0);
    drain();

    apply_config(16'($urandom_range(600, 300)), 16'($urandom_range(4000, 2500)),
                 16'($urandom_range(1000, 700)), 16'($urandom_range(2500, 1900)));
    no_gaps = 1'b1;
    gen_traffic(150, 85);
    drain();
    no_gaps = 1'b0;

    apply_config(PULSE_LIMIT_RST, SYNC_LIMIT_RST, MIN_VALUE_RST, MAX_VALUE_RST);
    gen_traffic(200, 75);
    drain();

    if (expected_events.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_events.size()));
    $display("Summary: %0d edges, %0d limit sets: %0d mark %0d sync %0d ok %0d bad",
             items_sent, settings, kind_count[EV_MARK], kind_count[EV_SYNC],
             kind_count[EV_ACCEPT], kind_count[EV_REJECT]);
    $display("Summary: %0d mismatches in %0d results", errors, results_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ppm_fd_pkg.sv
hw/rtl/ppm_fd_chan_table.sv
hw/rtl/ppm_frame_decoder_core.sv
hw/rtl/ppm_fd_checker.sv
sim/tb_top.sv
